// ----- sv/srvhr_pkg.sv -----
// Package for the servo homing ramp: configuration and queue item types,
// timing and duty constants, command codes and the shared window clamp.
// No dependencies.
package srvhr_pkg;

    localparam logic [9:0] BOOT_WAIT_TICKS = 10'd80;
    localparam logic [9:0] SETTLE_TICKS    = 10'd120;
    localparam logic [9:0] MIN_STEP_TICKS  = 10'd20;
    localparam logic [9:0] STEP_NUM        = 10'd1000;

    localparam longint DUTY_MIN   = 250;
    localparam longint DUTY_MAX   = 1250;
    localparam longint ANGLE_SPAN = 180;
    localparam int     DUTY_SHIFT = 16;
    localparam logic [31:0] DUTY_MUL = 32'(((DUTY_MAX - DUTY_MIN) * (64'd1 << DUTY_SHIFT)
                                            + ANGLE_SPAN - 1) / ANGLE_SPAN);

    localparam logic [7:0]         ANGLE_MAX   = 8'd180;
    localparam logic signed [10:0] ANGLE_MAX_S = 11'sd180;

    localparam logic [3:0] DIV_LAST = 4'd9;

    localparam logic [8:0] SPEED_MIN = 9'd1;
    localparam logic [8:0] SPEED_MAX = 9'd360;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_RESOLVE = 2'd2;
    localparam logic [1:0] KIND_NOP     = 2'd3;

    localparam logic [2:0] REG_START   = 3'd0;
    localparam logic [2:0] REG_HOME    = 3'd1;
    localparam logic [2:0] REG_TRIM    = 3'd2;
    localparam logic [2:0] REG_LIMIT   = 3'd3;
    localparam logic [2:0] REG_REVERSE = 3'd4;
    localparam logic [2:0] REG_SPEED   = 3'd5;

    typedef logic [1:0] kind_t;

    typedef struct packed {
        logic [7:0]        start_angle;
        logic [7:0]        home_angle;
        logic signed [5:0] trim_angle;
        logic [7:0]        limit_angle;
        logic              reverse_dir;
        logic [8:0]        ramp_speed;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic signed [8:0] resolved;
    } item_t;

    function automatic logic [7:0] home_clamp(input logic [7:0] home);
        return (home > ANGLE_MAX) ? ANGLE_MAX : home;
    endfunction

    function automatic logic [7:0] window_clamp(
        input logic signed [10:0] deg,
        input logic [7:0]         home,
        input logic [7:0]         limit
    );
        logic [7:0]         h;
        logic signed [10:0] lo;
        logic signed [10:0] hi;
        logic signed [10:0] r;
        h  = home_clamp(home);
        lo = $signed({3'b000, h}) - $signed({3'b000, limit});
        hi = $signed({3'b000, h}) + $signed({3'b000, limit});
        if (lo < 0)
            lo = '0;
        if (hi > ANGLE_MAX_S)
            hi = ANGLE_MAX_S;
        r = deg;
        if (deg < lo)
            r = lo;
        else if (deg > hi)
            r = hi;
        return r[7:0];
    endfunction

endpackage

// ----- sv/srvhr_ifs.sv -----
// Valid/ready channel interfaces for command transactions and result transactions.
// No dependencies.
interface srvhr_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic signed [8:0] offset_deg;

    modport source (output valid, output cmd, output offset_deg, input ready);
    modport sink   (input valid, input cmd, input offset_deg, output ready);
endinterface

interface srvhr_out_if;
    logic              valid;
    logic              ready;
    logic [10:0]       duty;
    logic [7:0]        commanded_angle;
    logic signed [8:0] resolved_angle;
    logic              busy_res;
    logic              done_res;

    modport source (output valid, output duty, output commanded_angle,
                    output resolved_angle, output busy_res, output done_res, input ready);
    modport sink   (input valid, input duty, input commanded_angle,
                    input resolved_angle, input busy_res, input done_res, output ready);
endinterface

// ----- sv/srvhr_front.sv -----
// Front end: accepts command transactions, decodes the command and answers resolve.
// Depends on srvhr_pkg and srvhr_in_if.
module srvhr_front (
    srvhr_in_if.sink          item,
    input  srvhr_pkg::cfg_t   cfg,
    output logic              push_valid,
    input  logic              push_ready,
    output srvhr_pkg::item_t  push_data
);

    logic [7:0]         home_w;
    logic signed [10:0] target_deg;
    logic [7:0]         win_w;
    logic signed [8:0]  answer;

    assign home_w     = srvhr_pkg::home_clamp(cfg.home_angle);
    assign target_deg = $signed({3'b000, home_w}) + {{2{item.offset_deg[8]}}, item.offset_deg};
    assign win_w      = srvhr_pkg::window_clamp(target_deg, cfg.home_angle, cfg.limit_angle);
    assign answer     = $signed({1'b0, win_w}) + {{3{cfg.trim_angle[5]}}, cfg.trim_angle};

    assign push_valid = item.valid;
    assign item.ready = push_ready;

    always_comb
    begin
        push_data.resolved = '0;
        case (item.cmd)
            srvhr_pkg::CMD_TICK:    push_data.kind = srvhr_pkg::KIND_TICK;
            srvhr_pkg::CMD_START:   push_data.kind = srvhr_pkg::KIND_START;
            srvhr_pkg::CMD_RESOLVE:
            begin
                push_data.kind     = srvhr_pkg::KIND_RESOLVE;
                push_data.resolved = answer;
            end
            default:                push_data.kind = srvhr_pkg::KIND_NOP;
        endcase
    end

endmodule

// ----- sv/srvhr_queue.sv -----
// Small FIFO of decoded transactions between the front end and the sequencer.
// Depends on srvhr_pkg.
module srvhr_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  srvhr_pkg::item_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output srvhr_pkg::item_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srvhr_pkg::item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/srvhr_back.sv -----
// Sequencer: homing phases, step timing, bit-serial step-period divide, duty
// conversion and the result register. Depends on srvhr_pkg and srvhr_out_if.
module srvhr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  srvhr_pkg::cfg_t  cfg,
    input  logic             q_valid,
    output logic             q_pop,
    input  srvhr_pkg::item_t q_data,
    srvhr_out_if.source      result
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_BOOT   = 3'd1;
    localparam logic [2:0] PH_RAMP   = 3'd2;
    localparam logic [2:0] PH_SETTLE = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic B_RUN = 1'b0;
    localparam logic B_DIV = 1'b1;

    function automatic logic [10:0] duty_of(
        input logic [7:0]        ang,
        input logic signed [5:0] trim,
        input logic              rev
    );
        logic signed [9:0] sum;
        logic [7:0]        a;
        logic [31:0]       prod;
        sum = $signed({2'b00, ang}) + {{4{trim[5]}}, trim};
        if (sum < 0)
            a = '0;
        else if (sum > 10'sd180)
            a = srvhr_pkg::ANGLE_MAX;
        else
            a = sum[7:0];
        if (rev)
            a = srvhr_pkg::ANGLE_MAX - a;
        prod = {24'b0, a} * srvhr_pkg::DUTY_MUL;
        return 11'(srvhr_pkg::DUTY_MIN + longint'(prod >> srvhr_pkg::DUTY_SHIFT));
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [9:0]  wait_count_reg, wait_count_next;
    logic [9:0]  step_ticks_reg, step_ticks_next;
    logic [7:0]  current_angle_reg, current_angle_next;
    logic [7:0]  target_angle_reg, target_angle_next;
    logic        step_dir_reg, step_dir_next;
    logic [10:0] duty_reg, duty_next;
    logic        bstate_reg, bstate_next;
    logic [3:0]  div_cnt_reg, div_cnt_next;
    logic [8:0]  rem_reg, rem_next;
    logic [9:0]  quo_reg, quo_next;
    logic [9:0]  num_reg, num_next;
    logic [7:0]  start_pos_reg, start_pos_next;
    logic        out_valid_reg, out_valid_next;

    logic [10:0]       out_duty_reg;
    logic [7:0]        out_angle_reg;
    logic signed [8:0] out_resolved_reg;
    logic              out_busy_reg;
    logic              out_done_reg;

    logic              out_free;
    logic              load;
    logic              duty_load;
    logic [7:0]        duty_ang;
    logic signed [8:0] resolved_w;
    logic [9:0]        wc_dec;
    logic [9:0]        trial;
    logic [9:0]        trial_diff;
    logic              fit;
    logic [9:0]        quo_shift;
    logic [9:0]        step_d;
    logic [7:0]        step_from;
    logic [7:0]        step_ang;
    logic [7:0]        s_ang;
    logic [7:0]        t_ang;
    logic              phase_busy;

    assign out_free   = !out_valid_reg || result.ready;
    assign phase_busy = (phase_reg inside {PH_BOOT, PH_RAMP, PH_SETTLE});
    assign wc_dec     = (wait_count_reg != '0) ? wait_count_reg - 10'd1 : '0;
    assign s_ang      = srvhr_pkg::window_clamp($signed({3'b000, cfg.start_angle}),
                                                cfg.home_angle, cfg.limit_angle);
    assign t_ang      = srvhr_pkg::window_clamp($signed({3'b000, cfg.home_angle}),
                                                cfg.home_angle, cfg.limit_angle);
    assign trial      = {rem_reg, num_reg[9]};
    assign fit        = (trial >= {1'b0, cfg.ramp_speed});
    assign trial_diff = trial - {1'b0, cfg.ramp_speed};
    assign quo_shift  = {quo_reg[8:0], fit};
    assign step_d     = (quo_shift < srvhr_pkg::MIN_STEP_TICKS) ?
                        srvhr_pkg::MIN_STEP_TICKS : quo_shift;
    assign step_from  = (bstate_reg == B_DIV) ? start_pos_reg : current_angle_reg;
    assign step_ang   = step_dir_reg ? step_from - 8'd1 : step_from + 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        wait_count_next    = wait_count_reg;
        step_ticks_next    = step_ticks_reg;
        current_angle_next = current_angle_reg;
        target_angle_next  = target_angle_reg;
        step_dir_next      = step_dir_reg;
        duty_next          = duty_reg;
        bstate_next        = bstate_reg;
        div_cnt_next       = div_cnt_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        num_next           = num_reg;
        start_pos_next     = start_pos_reg;
        q_pop              = 1'b0;
        load               = 1'b0;
        duty_load          = 1'b0;
        duty_ang           = target_angle_reg;
        resolved_w         = '0;

        case (bstate_reg)
            B_RUN:
            begin
                if (q_valid && out_free)
                begin
                    q_pop      = 1'b1;
                    load       = 1'b1;
                    resolved_w = q_data.resolved;
                    case (q_data.kind)
                        srvhr_pkg::KIND_TICK:
                        begin
                            if (phase_busy)
                            begin
                                wait_count_next = wc_dec;
                                if (wc_dec == '0)
                                begin
                                    case (phase_reg)
                                        PH_BOOT:
                                        begin
                                            target_angle_next = t_ang;
                                            if (s_ang == t_ang)
                                            begin
                                                current_angle_next = t_ang;
                                                duty_ang           = t_ang;
                                                duty_load          = 1'b1;
                                                phase_next         = PH_DONE;
                                            end
                                            else
                                            begin
                                                load           = 1'b0;
                                                bstate_next    = B_DIV;
                                                div_cnt_next   = '0;
                                                rem_next       = '0;
                                                quo_next       = '0;
                                                num_next       = srvhr_pkg::STEP_NUM;
                                                start_pos_next = s_ang;
                                                step_dir_next  = (t_ang < s_ang);
                                            end
                                        end
                                        PH_RAMP:
                                        begin
                                            if (current_angle_reg == target_angle_reg)
                                            begin
                                                current_angle_next = target_angle_reg;
                                                duty_ang           = target_angle_reg;
                                                duty_load          = 1'b1;
                                                if (srvhr_pkg::SETTLE_TICKS == '0)
                                                    phase_next = PH_DONE;
                                                else
                                                begin
                                                    phase_next      = PH_SETTLE;
                                                    wait_count_next = srvhr_pkg::SETTLE_TICKS;
                                                end
                                            end
                                            else
                                            begin
                                                current_angle_next = step_ang;
                                                duty_ang           = step_ang;
                                                duty_load          = 1'b1;
                                                wait_count_next    = step_ticks_reg;
                                            end
                                        end
                                        PH_SETTLE: phase_next = PH_DONE;
                                        default: ;
                                    endcase
                                end
                            end
                        end
                        srvhr_pkg::KIND_START:
                        begin
                            current_angle_next = (cfg.start_angle > srvhr_pkg::ANGLE_MAX) ?
                                                 srvhr_pkg::ANGLE_MAX : cfg.start_angle;
                            duty_ang           = cfg.start_angle;
                            duty_load          = 1'b1;
                            wait_count_next    = srvhr_pkg::BOOT_WAIT_TICKS;
                            phase_next         = PH_BOOT;
                        end
                        default: ;
                    endcase
                end
            end
            B_DIV:
            begin
                rem_next     = fit ? trial_diff[8:0] : trial[8:0];
                quo_next     = quo_shift;
                num_next     = {num_reg[8:0], 1'b0};
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == srvhr_pkg::DIV_LAST)
                begin
                    step_ticks_next    = step_d;
                    wait_count_next    = step_d;
                    current_angle_next = step_ang;
                    duty_ang           = step_ang;
                    duty_load          = 1'b1;
                    phase_next         = PH_RAMP;
                    load               = 1'b1;
                    bstate_next        = B_RUN;
                end
            end
            default: bstate_next = B_RUN;
        endcase

        if (duty_load)
            duty_next = duty_of(duty_ang, cfg.trim_angle, cfg.reverse_dir);

        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            wait_count_reg    <= '0;
            step_ticks_reg    <= '0;
            current_angle_reg <= '0;
            target_angle_reg  <= '0;
            step_dir_reg      <= 1'b0;
            duty_reg          <= 11'(srvhr_pkg::DUTY_MIN);
            bstate_reg        <= B_RUN;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            wait_count_reg    <= wait_count_next;
            step_ticks_reg    <= step_ticks_next;
            current_angle_reg <= current_angle_next;
            target_angle_reg  <= target_angle_next;
            step_dir_reg      <= step_dir_next;
            duty_reg          <= duty_next;
            bstate_reg        <= bstate_next;
            div_cnt_reg       <= div_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        num_reg       <= num_next;
        start_pos_reg <= start_pos_next;
        if (load)
        begin
            out_duty_reg     <= duty_next;
            out_angle_reg    <= current_angle_next;
            out_resolved_reg <= resolved_w;
            out_busy_reg     <= (phase_next inside {PH_BOOT, PH_RAMP, PH_SETTLE});
            out_done_reg     <= (phase_next == PH_DONE);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.duty            = out_duty_reg;
    assign result.commanded_angle = out_angle_reg;
    assign result.resolved_angle  = out_resolved_reg;
    assign result.busy_res        = out_busy_reg;
    assign result.done_res        = out_done_reg;

    a_div_in_boot: assert property (@(posedge clk) disable iff (!rst_n)
        bstate_reg == B_DIV |-> phase_reg == PH_BOOT)
        else $error("divide running outside the boot phase");

    a_div_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bstate_reg == B_DIV |-> !out_valid_reg)
        else $error("result register occupied during divide");

    a_ramp_target: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RAMP && $past(phase_reg) == PH_RAMP) |-> $stable(target_angle_reg))
        else $error("ramp target changed mid ramp");

    a_ramp_period: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RAMP |-> (step_ticks_reg >= srvhr_pkg::MIN_STEP_TICKS
                                  && wait_count_reg <= step_ticks_reg))
        else $error("step timer out of range");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_duty_reg >= 11'(srvhr_pkg::DUTY_MIN)
                           && out_duty_reg <= 11'(srvhr_pkg::DUTY_MAX)))
        else $error("duty outside the pulse range");

endmodule

// ----- sv/servo_homing_ramp.sv -----
// Servo homing ramp, one channel: the sequencer pops each queued transaction and
// registers its result, one per cycle while results are taken and no divide runs.
// The tick ending the boot wait with a move to make runs the bit-serial step-period
// divide first and pops nothing until done. Up to QUEUE_DEPTH transactions wait
// between parts. Reset: config to defaults, phase idle, duty 250, queue, result empty.
// Depends on srvhr_pkg, srvhr_ifs, srvhr_front, srvhr_queue and srvhr_back.
module servo_homing_ramp #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    srvhr_in_if.sink    item,
    srvhr_out_if.source result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    srvhr_pkg::cfg_t  cfg_reg, cfg_next;
    srvhr_pkg::item_t push_data;
    srvhr_pkg::item_t pop_data;
    logic             push_valid;
    logic             push_ready;
    logic             pop_valid;
    logic             pop_ready;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                srvhr_pkg::REG_START:   cfg_next.start_angle = pwdata[7:0];
                srvhr_pkg::REG_HOME:    cfg_next.home_angle  = pwdata[7:0];
                srvhr_pkg::REG_TRIM:    cfg_next.trim_angle  = $signed(pwdata[5:0]);
                srvhr_pkg::REG_LIMIT:   cfg_next.limit_angle = pwdata[7:0];
                srvhr_pkg::REG_REVERSE: cfg_next.reverse_dir = pwdata[0];
                srvhr_pkg::REG_SPEED:
                begin
                    if (pwdata[8:0] inside {[srvhr_pkg::SPEED_MIN:srvhr_pkg::SPEED_MAX]})
                        cfg_next.ramp_speed = pwdata[8:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            srvhr_pkg::REG_START:   prdata = {24'b0, cfg_reg.start_angle};
            srvhr_pkg::REG_HOME:    prdata = {24'b0, cfg_reg.home_angle};
            srvhr_pkg::REG_TRIM:    prdata = {{26{cfg_reg.trim_angle[5]}}, cfg_reg.trim_angle};
            srvhr_pkg::REG_LIMIT:   prdata = {24'b0, cfg_reg.limit_angle};
            srvhr_pkg::REG_REVERSE: prdata = {31'b0, cfg_reg.reverse_dir};
            srvhr_pkg::REG_SPEED:   prdata = {23'b0, cfg_reg.ramp_speed};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle <= 8'd45;
            cfg_reg.home_angle  <= 8'd0;
            cfg_reg.trim_angle  <= 6'sd3;
            cfg_reg.limit_angle <= 8'd60;
            cfg_reg.reverse_dir <= 1'b0;
            cfg_reg.ramp_speed  <= 9'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    srvhr_front u_front (
        .item       (item),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    srvhr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    srvhr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (pop_valid),
        .q_pop   (pop_ready),
        .q_data  (pop_data),
        .result  (result)
    );

endmodule

// ----- verif/tb_servo_homing_ramp.sv -----
// Testbench for servo_homing_ramp: directed and random command streams under
// sender bursts and receiver stalls, checked against an in-bench homing predictor.
// Depends on srvhr_pkg, srvhr_ifs and the servo_homing_ramp RTL.
`timescale 1ns / 1ps

module tb_servo_homing_ramp;

    localparam logic [1:0] CMD_NOP      = 2'd3;
    localparam int         RANDOM_ITEMS = 1650;
    localparam int         CYCLE_LIMIT  = 400000;

    typedef enum logic [2:0] {
        HOMING_IDLE,
        HOMING_BOOT,
        HOMING_RAMP,
        HOMING_SETTLE,
        HOMING_DONE
    } homing_phase_t;

    typedef struct packed {
        logic [10:0]       duty;
        logic [7:0]        angle;
        logic signed [8:0] resolved;
        logic              busy;
        logic              done;
    } servo_status_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    srvhr_in_if  cmd_ch ();
    srvhr_out_if status_ch ();

    servo_homing_ramp dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (cmd_ch),
        .result  (status_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    srvhr_pkg::cfg_t shadow_cfg;
    homing_phase_t   homing_ph;
    logic [9:0]      wait_left;
    logic [9:0]      step_period;
    logic [7:0]      cur_angle;
    logic [7:0]      tgt_angle;
    logic            step_down;
    logic [10:0]     duty_now;

    servo_status_t pending_status[$];
    bit            failed        = 1'b0;
    int            counted_items = 0;
    int            burst_left    = 0;
    int            cycle_count   = 0;
    int            stall_mode    = 0;
    int            stall_left    = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** servo_homing_ramp: FAILED **");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       status_ch.ready <= 1'b1;
            1:       status_ch.ready <= (cycle_count % 3) != 0;
            2:       status_ch.ready <= 1'($urandom_range(0, 1));
            default: status_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        servo_status_t want;
        if (rst_n && status_ch.valid === 1'b1 && status_ch.ready === 1'b1)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status transaction arrived with none pending");
                failed = 1'b1;
            end
            else
            begin
                want = pending_status.pop_front();
                if (status_ch.duty !== want.duty)
                begin
                    $error("duty: expected %0d, got %0d", want.duty, status_ch.duty);
                    failed = 1'b1;
                end
                if (status_ch.commanded_angle !== want.angle)
                begin
                    $error("commanded_angle: expected %0d, got %0d",
                           want.angle, status_ch.commanded_angle);
                    failed = 1'b1;
                end
                if (status_ch.resolved_angle !== want.resolved)
                begin
                    $error("resolved_angle: expected %0d, got %0d",
                           $signed(want.resolved), $signed(status_ch.resolved_angle));
                    failed = 1'b1;
                end
                if (status_ch.busy_res !== want.busy)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy, status_ch.busy_res);
                    failed = 1'b1;
                end
                if (status_ch.done_res !== want.done)
                begin
                    $error("done_res: expected %0d, got %0d", want.done, status_ch.done_res);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic void reset_shadow();
        shadow_cfg.start_angle = 8'd45;
        shadow_cfg.home_angle  = 8'd0;
        shadow_cfg.trim_angle  = 6'sd3;
        shadow_cfg.limit_angle = 8'd60;
        shadow_cfg.reverse_dir = 1'b0;
        shadow_cfg.ramp_speed  = 9'd10;
        homing_ph   = HOMING_IDLE;
        wait_left   = '0;
        step_period = '0;
        cur_angle   = '0;
        tgt_angle   = '0;
        step_down   = 1'b0;
        duty_now    = 11'(srvhr_pkg::DUTY_MIN);
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] v);
        case (idx)
            srvhr_pkg::REG_START:   shadow_cfg.start_angle = v[7:0];
            srvhr_pkg::REG_HOME:    shadow_cfg.home_angle  = v[7:0];
            srvhr_pkg::REG_TRIM:    shadow_cfg.trim_angle  = v[5:0];
            srvhr_pkg::REG_LIMIT:   shadow_cfg.limit_angle = v[7:0];
            srvhr_pkg::REG_REVERSE: shadow_cfg.reverse_dir = v[0];
            srvhr_pkg::REG_SPEED:
                if (v[8:0] >= srvhr_pkg::SPEED_MIN && v[8:0] <= srvhr_pkg::SPEED_MAX)
                    shadow_cfg.ramp_speed = v[8:0];
            default: ;
        endcase
    endfunction

    function automatic int clamped_home();
        if (shadow_cfg.home_angle > srvhr_pkg::ANGLE_MAX)
            return int'(srvhr_pkg::ANGLE_MAX);
        return int'(shadow_cfg.home_angle);
    endfunction

    function automatic int trim_offset();
        return int'($signed(shadow_cfg.trim_angle));
    endfunction

    function automatic int window_deg(input int deg);
        int lo;
        int hi;
        lo = clamped_home() - int'(shadow_cfg.limit_angle);
        hi = clamped_home() + int'(shadow_cfg.limit_angle);
        if (lo < 0)
            lo = 0;
        if (hi > int'(srvhr_pkg::ANGLE_MAX))
            hi = int'(srvhr_pkg::ANGLE_MAX);
        if (deg < lo)
            return lo;
        if (deg > hi)
            return hi;
        return deg;
    endfunction

    function automatic logic [10:0] duty_for(input int a);
        int ang;
        ang = a + trim_offset();
        if (ang < 0)
            ang = 0;
        else if (ang > int'(srvhr_pkg::ANGLE_MAX))
            ang = int'(srvhr_pkg::ANGLE_MAX);
        if (shadow_cfg.reverse_dir)
            ang = int'(srvhr_pkg::ANGLE_MAX) - ang;
        return 11'(int'(srvhr_pkg::DUTY_MIN)
                   + ang * int'(srvhr_pkg::DUTY_MAX - srvhr_pkg::DUTY_MIN)
                   / int'(srvhr_pkg::ANGLE_SPAN));
    endfunction

    function automatic void drive_angle(input logic [7:0] a);
        cur_angle = a;
        duty_now  = duty_for(int'(a));
    endfunction

    function automatic void take_step();
        drive_angle(step_down ? cur_angle - 8'd1 : cur_angle + 8'd1);
        wait_left = step_period;
        homing_ph = HOMING_RAMP;
    endfunction

    function automatic void advance_phase();
        int         s;
        int         t;
        logic [9:0] d;
        case (homing_ph)
            HOMING_BOOT:
            begin
                s = window_deg(int'(shadow_cfg.start_angle));
                t = window_deg(int'(shadow_cfg.home_angle));
                tgt_angle = 8'(t);
                if (s == t)
                begin
                    drive_angle(tgt_angle);
                    homing_ph = HOMING_DONE;
                end
                else
                begin
                    d = srvhr_pkg::STEP_NUM / shadow_cfg.ramp_speed;
                    if (d < srvhr_pkg::MIN_STEP_TICKS)
                        d = srvhr_pkg::MIN_STEP_TICKS;
                    step_period = d;
                    step_down   = (t < s);
                    cur_angle   = 8'(s);
                    take_step();
                end
            end
            HOMING_RAMP:
            begin
                if (cur_angle == tgt_angle)
                begin
                    drive_angle(tgt_angle);
                    if (srvhr_pkg::SETTLE_TICKS == 0)
                    begin
                        homing_ph = HOMING_DONE;
                    end
                    else
                    begin
                        homing_ph = HOMING_SETTLE;
                        wait_left = srvhr_pkg::SETTLE_TICKS;
                    end
                end
                else
                begin
                    take_step();
                end
            end
            HOMING_SETTLE: homing_ph = HOMING_DONE;
            default: ;
        endcase
    endfunction

    function automatic bit homing_busy();
        return homing_ph == HOMING_BOOT || homing_ph == HOMING_RAMP
            || homing_ph == HOMING_SETTLE;
    endfunction

    function automatic void compute_status(input logic [1:0] op,
                                           input logic signed [8:0] off);
        servo_status_t s;
        int            r;
        r = 0;
        case (op)
            srvhr_pkg::CMD_TICK:
                if (homing_busy())
                begin
                    if (wait_left != 0)
                        wait_left--;
                    if (wait_left == 0)
                        advance_phase();
                end
            srvhr_pkg::CMD_START:
            begin
                cur_angle = (shadow_cfg.start_angle > srvhr_pkg::ANGLE_MAX) ?
                            srvhr_pkg::ANGLE_MAX : shadow_cfg.start_angle;
                duty_now  = duty_for(int'(shadow_cfg.start_angle));
                wait_left = srvhr_pkg::BOOT_WAIT_TICKS;
                homing_ph = HOMING_BOOT;
            end
            srvhr_pkg::CMD_RESOLVE: r = window_deg(clamped_home() + int'(off)) + trim_offset();
            default: ;
        endcase
        s.duty     = duty_now;
        s.angle    = cur_angle;
        s.resolved = 9'(r);
        s.busy     = homing_busy();
        s.done     = (homing_ph == HOMING_DONE);
        pending_status.push_back(s);
    endfunction

    function automatic int pick(input int lo, input int hi);
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) != 0) ? lo : hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [8:0] rand_offset();
        return 9'(pick(-256, 255));
    endfunction

    task automatic send_cmd(input logic [1:0] op, input logic signed [8:0] off);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= op;
        cmd_ch.offset_deg <= off;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        counted_items++;
        compute_status(op, off);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        apply_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic randomize_config(input bit narrow);
        reg_write(srvhr_pkg::REG_START, 32'(pick(0, 255)));
        reg_write(srvhr_pkg::REG_HOME, 32'(pick(0, 255)));
        reg_write(srvhr_pkg::REG_TRIM, 32'(pick(-32, 31)));
        reg_write(srvhr_pkg::REG_REVERSE, 32'($urandom_range(0, 1)));
        if (narrow)
        begin
            reg_write(srvhr_pkg::REG_LIMIT, 32'($urandom_range(0, 6)));
            reg_write(srvhr_pkg::REG_SPEED,
                      ($urandom_range(0, 4) == 0) ? 32'($urandom_range(20, 49))
                                                  : 32'(pick(50, 360)));
        end
        else
        begin
            reg_write(srvhr_pkg::REG_LIMIT, 32'(pick(0, 255)));
            case ($urandom_range(0, 3))
                0:       reg_write(srvhr_pkg::REG_SPEED, 32'(srvhr_pkg::SPEED_MIN));
                1:       reg_write(srvhr_pkg::REG_SPEED, 32'(srvhr_pkg::SPEED_MAX));
                default: reg_write(srvhr_pkg::REG_SPEED, 32'(pick(0, 511)));
            endcase
        end
    endtask

    task automatic send_homing_item();
        int roll;
        roll = $urandom_range(0, 199);
        if (roll < 176)
            send_cmd(srvhr_pkg::CMD_TICK, rand_offset());
        else if (roll < 188)
            send_cmd(srvhr_pkg::CMD_RESOLVE, rand_offset());
        else if (roll < 198)
            send_cmd(CMD_NOP, rand_offset());
        else
            send_cmd(srvhr_pkg::CMD_START, rand_offset());
    endtask

    task automatic run_until_done(input int cap);
        int n;
        n = 0;
        while (homing_ph != HOMING_DONE && n < cap && counted_items < RANDOM_ITEMS)
        begin
            send_homing_item();
            n++;
        end
    endtask

    task automatic test_idle_and_resolve();
        send_cmd(srvhr_pkg::CMD_TICK, 9'sd0);
        send_cmd(CMD_NOP, -9'sd1);
        send_cmd(srvhr_pkg::CMD_RESOLVE, -9'sd256);
        send_cmd(srvhr_pkg::CMD_RESOLVE, 9'sd255);
        send_cmd(srvhr_pkg::CMD_RESOLVE, -9'sd180);
        send_cmd(srvhr_pkg::CMD_RESOLVE, 9'sd180);
        send_cmd(srvhr_pkg::CMD_RESOLVE, 9'sd0);
    endtask

    task automatic test_boot_restart();
        send_cmd(srvhr_pkg::CMD_START, 9'sd0);
        repeat (3) send_cmd(srvhr_pkg::CMD_TICK, 9'sd0);
        send_cmd(srvhr_pkg::CMD_RESOLVE, 9'sd5);
        send_cmd(srvhr_pkg::CMD_START, 9'sd0);
        send_cmd(srvhr_pkg::CMD_TICK, 9'sd0);
        send_cmd(CMD_NOP, 9'sd0);
    endtask

    task automatic test_extreme_config();
        drain_results();
        reg_write(srvhr_pkg::REG_START, 32'd255);
        reg_write(srvhr_pkg::REG_HOME, 32'd255);
        reg_write(srvhr_pkg::REG_TRIM, 32'h20);
        reg_write(srvhr_pkg::REG_LIMIT, 32'd0);
        reg_write(srvhr_pkg::REG_REVERSE, 32'd1);
        reg_write(srvhr_pkg::REG_SPEED, 32'd0);
        reg_write(srvhr_pkg::REG_SPEED, 32'd361);
        reg_write(srvhr_pkg::REG_SPEED, 32'(srvhr_pkg::SPEED_MAX));
        send_cmd(srvhr_pkg::CMD_RESOLVE, -9'sd256);
        send_cmd(srvhr_pkg::CMD_RESOLVE, 9'sd255);
        send_cmd(srvhr_pkg::CMD_START, 9'sd0);
        send_cmd(srvhr_pkg::CMD_TICK, 9'sd0);
        drain_results();
        reg_write(srvhr_pkg::REG_START, 32'd0);
        reg_write(srvhr_pkg::REG_HOME, 32'd180);
        reg_write(srvhr_pkg::REG_TRIM, 32'd31);
        reg_write(srvhr_pkg::REG_LIMIT, 32'd255);
        reg_write(srvhr_pkg::REG_REVERSE, 32'd0);
        reg_write(srvhr_pkg::REG_SPEED, 32'(srvhr_pkg::SPEED_MIN));
        send_cmd(srvhr_pkg::CMD_RESOLVE, -9'sd1);
        send_cmd(srvhr_pkg::CMD_RESOLVE, 9'sd1);
        send_cmd(srvhr_pkg::CMD_START, 9'sd0);
        send_cmd(srvhr_pkg::CMD_TICK, 9'sd0);
    endtask

    task automatic test_midflight_config();
        int n;
        n = 0;
        drain_results();
        randomize_config(1'b1);
        send_cmd(srvhr_pkg::CMD_START, rand_offset());
        while (homing_ph != HOMING_RAMP && homing_ph != HOMING_DONE && n < 400)
        begin
            send_homing_item();
            n++;
        end
        repeat ($urandom_range(0, 30)) send_homing_item();
        drain_results();
        reg_write(srvhr_pkg::REG_HOME, 32'(pick(0, 255)));
        reg_write(srvhr_pkg::REG_LIMIT, 32'(pick(0, 255)));
        reg_write(srvhr_pkg::REG_TRIM, 32'(pick(-32, 31)));
        reg_write(srvhr_pkg::REG_REVERSE, 32'($urandom_range(0, 1)));
        reg_write(srvhr_pkg::REG_START, 32'(pick(0, 255)));
        run_until_done(1500);
    endtask

    task automatic test_random_homing();
        int kind;
        while (counted_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                drain_results();
                randomize_config(1'b1);
                send_cmd(srvhr_pkg::CMD_START, rand_offset());
                run_until_done(1500);
            end
            else if (kind < 8)
            begin
                drain_results();
                randomize_config(1'b0);
                send_cmd(srvhr_pkg::CMD_START, rand_offset());
                repeat ($urandom_range(50, 250)) send_homing_item();
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(20, 60))
                    send_cmd(2'($urandom_range(0, 3)), rand_offset());
            end
            else
            begin
                test_midflight_config();
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.cmd           = srvhr_pkg::CMD_TICK;
        cmd_ch.offset_deg    = '0;
        status_ch.ready      = 1'b0;
        reset_shadow();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_idle_and_resolve();
        test_boot_restart();
        test_extreme_config();
        test_midflight_config();
        test_random_homing();

        drain_results();
        repeat (20) @(posedge clk);
        if (!failed)
            $display("** servo_homing_ramp: PASSED **");
        else
            $display("** servo_homing_ramp: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/srvhr_pkg.sv
sv/srvhr_ifs.sv
sv/srvhr_front.sv
sv/srvhr_queue.sv
sv/srvhr_back.sv
sv/servo_homing_ramp.sv
verif/tb_servo_homing_ramp.sv
